>>> rtl/lbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

	// Palette geometry
	localparam int JOINT_COUNT = 64;
	localparam int MAT_ENTRIES = 12;
	localparam int PAL_DEPTH   = JOINT_COUNT * MAT_ENTRIES;
	localparam int PAL_AW      = $clog2(PAL_DEPTH);

	// Field widths
	localparam int JOINT_W = 6;
	localparam int ELEM_W  = 4;
	localparam int VAL_W   = 32;
	localparam int WGT_W   = 17;
	localparam int POS_W   = 32;
	localparam int NRM_W   = 16;

	// Input word layout, lowest bit first
	localparam int OFS_JOINT = 0;
	localparam int OFS_ELEM  = OFS_JOINT + JOINT_W;
	localparam int OFS_VAL   = OFS_ELEM + ELEM_W;
	localparam int OFS_WGT   = OFS_VAL + VAL_W;
	localparam int OFS_PX    = OFS_WGT + WGT_W;
	localparam int OFS_PY    = OFS_PX + POS_W;
	localparam int OFS_PZ    = OFS_PY + POS_W;
	localparam int OFS_NX    = OFS_PZ + POS_W;
	localparam int OFS_NY    = OFS_NX + NRM_W;
	localparam int OFS_NZ    = OFS_NY + NRM_W;
	localparam int IN_BITS   = OFS_NZ + NRM_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// Output word width
	localparam int OUT_DATA_W = 3 * POS_W + 3 * NRM_W;

	// Arithmetic widths
	localparam int ACC_W  = 48;
	localparam int MQ_W   = 33;
	localparam int PROD_W = 2 * MQ_W;
	localparam int SUM_W  = 52;

	localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(65536);

	// Request kinds carried in tuser
	typedef enum logic {
		REQ_WRITE     = 1'b0,
		REQ_INFLUENCE = 1'b1
	} req_t;

	// What the product register holds
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_ACC,
		MUL_POS,
		MUL_NRM
	} mul_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_DRAIN,
		ST_FIN_LOAD,
		ST_FIN_MULP,
		ST_FIN_MULN,
		ST_FIN_TRANS,
		ST_FIN_ROW,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              capture;
		logic              pal_wr;
		logic              rd_en;
		logic [ELEM_W-1:0] elem;
		logic              fin_load;
		logic              sum_clr;
		mul_kind_t         fin_mul;
		logic [1:0]        col;
		logic              add_trans;
		logic              row_done;
		logic [1:0]        row;
		logic              out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic joint_ok;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/lbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lbs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_kind,
	input  wire logic             in_last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire lbs_pkg::status_t st,
	output lbs_pkg::cmd_t         cmd
);

	lbs_pkg::state_t            state_q, state_d;
	logic [lbs_pkg::ELEM_W-1:0] cnt_q, cnt_d;
	logic [1:0]                 col_q, col_d;
	logic [1:0]                 row_q, row_d;
	logic                       drain_q, drain_d;
	logic                       last_q, last_d;
	logic                       out_valid_q, out_valid_d;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbs_pkg::ST_IDLE;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			drain_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			col_q       <= col_d;
			row_q       <= row_d;
			drain_q     <= drain_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		col_d     = col_q;
		row_d     = row_q;
		drain_d   = drain_q;
		last_d    = last_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.elem  = cnt_q;
		cmd.col   = col_q;
		cmd.row   = row_q;
		cmd.fin_mul = lbs_pkg::MUL_NONE;

		unique case (state_q)
			lbs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == lbs_pkg::REQ_INFLUENCE) begin
						cmd.capture = 1'b1;
						last_d      = in_last;
						col_d       = '0;
						row_d       = '0;
						if (st.joint_ok) begin
							cnt_d   = '0;
							state_d = lbs_pkg::ST_ACC_RD;
						end else if (in_last) begin
							state_d = lbs_pkg::ST_FIN_LOAD;
						end
					end else begin
						cmd.pal_wr = 1'b1;
					end
				end
			end
			lbs_pkg::ST_ACC_RD: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == lbs_pkg::ELEM_W'(lbs_pkg::MAT_ENTRIES - 1)) begin
					drain_d = 1'b0;
					state_d = lbs_pkg::ST_ACC_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			lbs_pkg::ST_ACC_DRAIN: begin
				// Wait for the read and multiply stages to empty.
				if (drain_q) begin
					state_d = last_q ? lbs_pkg::ST_FIN_LOAD : lbs_pkg::ST_IDLE;
				end else begin
					drain_d = 1'b1;
				end
			end
			lbs_pkg::ST_FIN_LOAD: begin
				cmd.fin_load = 1'b1;
				cmd.sum_clr  = (col_q == 2'd0);
				state_d = (col_q == 2'd3) ? lbs_pkg::ST_FIN_TRANS : lbs_pkg::ST_FIN_MULP;
			end
			lbs_pkg::ST_FIN_MULP: begin
				cmd.fin_mul = lbs_pkg::MUL_POS;
				state_d     = lbs_pkg::ST_FIN_MULN;
			end
			lbs_pkg::ST_FIN_MULN: begin
				cmd.fin_mul = lbs_pkg::MUL_NRM;
				col_d       = col_q + 1'b1;
				state_d     = lbs_pkg::ST_FIN_LOAD;
			end
			lbs_pkg::ST_FIN_TRANS: begin
				cmd.add_trans = 1'b1;
				state_d       = lbs_pkg::ST_FIN_ROW;
			end
			lbs_pkg::ST_FIN_ROW: begin
				cmd.row_done = 1'b1;
				col_d        = '0;
				if (row_q == 2'd2) begin
					state_d = lbs_pkg::ST_OUT;
				end else begin
					row_d   = row_q + 1'b1;
					state_d = lbs_pkg::ST_FIN_LOAD;
				end
			end
			lbs_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = lbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lbs_pkg::ST_IDLE;
			end
		endcase

		// Output word flag: set on load, cleared when taken.
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/lbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lbs_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lbs_pkg::IN_DATA_W-1:0]   in_data,
	input  wire lbs_pkg::cmd_t                   cmd,
	output lbs_pkg::status_t                     st,
	output logic [lbs_pkg::OUT_DATA_W-1:0]       out_data
);

	localparam int NE = lbs_pkg::MAT_ENTRIES;

	// Input fields
	logic [lbs_pkg::JOINT_W-1:0] f_joint;
	logic [lbs_pkg::ELEM_W-1:0]  f_elem;
	logic [lbs_pkg::VAL_W-1:0]   f_val;
	logic [lbs_pkg::WGT_W-1:0]   f_wgt;
	logic                        wr_ok;
	logic [lbs_pkg::PAL_AW-1:0]  wr_addr;

	assign f_joint = in_data[lbs_pkg::OFS_JOINT +: lbs_pkg::JOINT_W];
	assign f_elem  = in_data[lbs_pkg::OFS_ELEM +: lbs_pkg::ELEM_W];
	assign f_val   = in_data[lbs_pkg::OFS_VAL +: lbs_pkg::VAL_W];
	assign f_wgt   = in_data[lbs_pkg::OFS_WGT +: lbs_pkg::WGT_W];

	assign st.joint_ok = (32'(f_joint) < lbs_pkg::JOINT_COUNT);
	assign wr_ok = st.joint_ok && (32'(f_elem) < lbs_pkg::MAT_ENTRIES);
	assign wr_addr = lbs_pkg::PAL_AW'(f_joint) * lbs_pkg::PAL_AW'(NE)
		+ lbs_pkg::PAL_AW'(f_elem);

	// Captured influence payload
	logic [lbs_pkg::JOINT_W-1:0]      joint_q;
	logic [lbs_pkg::WGT_W-1:0]        weight_q;
	logic signed [lbs_pkg::POS_W-1:0] p_q [3];
	logic signed [lbs_pkg::NRM_W-1:0] n_q [3];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			joint_q  <= f_joint;
			weight_q <= (f_wgt > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : f_wgt;
			p_q[0]   <= $signed(in_data[lbs_pkg::OFS_PX +: lbs_pkg::POS_W]);
			p_q[1]   <= $signed(in_data[lbs_pkg::OFS_PY +: lbs_pkg::POS_W]);
			p_q[2]   <= $signed(in_data[lbs_pkg::OFS_PZ +: lbs_pkg::POS_W]);
			n_q[0]   <= $signed(in_data[lbs_pkg::OFS_NX +: lbs_pkg::NRM_W]);
			n_q[1]   <= $signed(in_data[lbs_pkg::OFS_NY +: lbs_pkg::NRM_W]);
			n_q[2]   <= $signed(in_data[lbs_pkg::OFS_NZ +: lbs_pkg::NRM_W]);
		end
	end

	// Matrix palette memory, one write or one registered read per cycle.
	logic [lbs_pkg::VAL_W-1:0]  pal_mem [lbs_pkg::PAL_DEPTH];
	logic [lbs_pkg::VAL_W-1:0]  rdata_s1;
	logic [lbs_pkg::PAL_AW-1:0] rd_addr;
	logic                       rd_vld_s1;

	assign rd_addr = lbs_pkg::PAL_AW'(joint_q) * lbs_pkg::PAL_AW'(NE)
		+ lbs_pkg::PAL_AW'(cmd.elem);

	always_ff @(posedge clk) begin
		if (cmd.pal_wr && wr_ok) begin
			pal_mem[wr_addr] <= f_val;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= pal_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	// Shared multiplier: weight times entry, or entry times coordinate.
	logic signed [lbs_pkg::MQ_W-1:0]   mq_q;
	logic signed [lbs_pkg::MQ_W-1:0]   mul_a, mul_b;
	logic signed [lbs_pkg::PROD_W-1:0] prod_s2;
	lbs_pkg::mul_kind_t                prod_kind_s2;
	logic signed [lbs_pkg::POS_W-1:0]  p_sel;
	logic signed [lbs_pkg::NRM_W-1:0]  n_sel;

	always_comb begin
		case (cmd.col)
			2'd0: begin
				p_sel = p_q[0];
				n_sel = n_q[0];
			end
			2'd1: begin
				p_sel = p_q[1];
				n_sel = n_q[1];
			end
			default: begin
				p_sel = p_q[2];
				n_sel = n_q[2];
			end
		endcase
		if (rd_vld_s1) begin
			mul_a = $signed({rdata_s1[lbs_pkg::VAL_W-1], rdata_s1});
			mul_b = $signed({{(lbs_pkg::MQ_W - lbs_pkg::WGT_W){1'b0}}, weight_q});
		end else if (cmd.fin_mul == lbs_pkg::MUL_POS) begin
			mul_a = mq_q;
			mul_b = lbs_pkg::MQ_W'(p_sel);
		end else begin
			mul_a = mq_q;
			mul_b = lbs_pkg::MQ_W'(n_sel);
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_kind_s2 <= lbs_pkg::MUL_NONE;
		end else begin
			prod_kind_s2 <= rd_vld_s1 ? lbs_pkg::MUL_ACC : cmd.fin_mul;
		end
	end

	// Rotating accumulator: entry 0 is worked on and moves to the back.
	logic signed [lbs_pkg::ACC_W-1:0] acc_q [NE];
	logic signed [lbs_pkg::ACC_W+1:0] acc_sum;
	logic signed [lbs_pkg::ACC_W-1:0] acc_sat;
	logic signed [lbs_pkg::ACC_W:0]   acc_rnd;

	always_comb begin
		acc_sum = (lbs_pkg::ACC_W+2)'(acc_q[0])
			+ (lbs_pkg::ACC_W+2)'($signed(prod_s2[lbs_pkg::ACC_W:0]));
		if (acc_sum[lbs_pkg::ACC_W+1:lbs_pkg::ACC_W-1] == 3'b000
			|| acc_sum[lbs_pkg::ACC_W+1:lbs_pkg::ACC_W-1] == 3'b111) begin
			acc_sat = acc_sum[lbs_pkg::ACC_W-1:0];
		end else if (acc_sum[lbs_pkg::ACC_W+1]) begin
			acc_sat = {1'b1, {(lbs_pkg::ACC_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(lbs_pkg::ACC_W-1){1'b1}}};
		end
		// Round half up to Q16.16.
		acc_rnd = (lbs_pkg::ACC_W+1)'(acc_q[0]) + (lbs_pkg::ACC_W+1)'(32768);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NE; i++) begin
				acc_q[i] <= '0;
			end
		end else if (prod_kind_s2 == lbs_pkg::MUL_ACC || cmd.fin_load) begin
			for (int i = 0; i < NE - 1; i++) begin
				acc_q[i] <= acc_q[i+1];
			end
			acc_q[NE-1] <= cmd.fin_load ? '0 : acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			mq_q <= acc_rnd[lbs_pkg::ACC_W:16];
		end
	end

	// Row sums for the position and the normal.
	logic signed [lbs_pkg::SUM_W-1:0] sp_q, sn_q;
	logic signed [lbs_pkg::SUM_W-1:0] sn_rnd;
	logic signed [lbs_pkg::POS_W-1:0] sp_sat;
	logic signed [lbs_pkg::NRM_W-1:0] sn_sat;
	logic signed [lbs_pkg::SUM_W-17:0] sn_shr;

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sp_q <= '0;
			sn_q <= '0;
		end else if (cmd.add_trans) begin
			sp_q <= sp_q + lbs_pkg::SUM_W'(mq_q);
		end else if (prod_kind_s2 == lbs_pkg::MUL_POS) begin
			sp_q <= sp_q + lbs_pkg::SUM_W'($signed(prod_s2[lbs_pkg::PROD_W-1:16]));
		end else if (prod_kind_s2 == lbs_pkg::MUL_NRM) begin
			sn_q <= sn_q + prod_s2[lbs_pkg::SUM_W-1:0];
		end
	end

	// Saturate a finished row.
	always_comb begin
		if (sp_q > lbs_pkg::SUM_W'(64'sh7FFF_FFFF)) begin
			sp_sat = {1'b0, {(lbs_pkg::POS_W-1){1'b1}}};
		end else if (sp_q < -lbs_pkg::SUM_W'(64'sh8000_0000)) begin
			sp_sat = {1'b1, {(lbs_pkg::POS_W-1){1'b0}}};
		end else begin
			sp_sat = sp_q[lbs_pkg::POS_W-1:0];
		end
		sn_rnd = sn_q + lbs_pkg::SUM_W'(32768);
		sn_shr = sn_rnd[lbs_pkg::SUM_W-1:16];
		if (sn_shr > (lbs_pkg::SUM_W-16)'(32767)) begin
			sn_sat = {1'b0, {(lbs_pkg::NRM_W-1){1'b1}}};
		end else if (sn_shr < -(lbs_pkg::SUM_W-16)'(32768)) begin
			sn_sat = {1'b1, {(lbs_pkg::NRM_W-1){1'b0}}};
		end else begin
			sn_sat = sn_shr[lbs_pkg::NRM_W-1:0];
		end
	end

	logic signed [lbs_pkg::POS_W-1:0] res_p_q [3];
	logic signed [lbs_pkg::NRM_W-1:0] res_n_q [3];
	logic [lbs_pkg::OUT_DATA_W-1:0]   out_data_q;

	always_ff @(posedge clk) begin
		if (cmd.row_done) begin
			res_p_q[cmd.row] <= sp_sat;
			res_n_q[cmd.row] <= sn_sat;
		end
		if (cmd.out_load) begin
			out_data_q <= {res_n_q[2], res_n_q[1], res_n_q[0],
				res_p_q[2], res_p_q[1], res_p_q[0]};
		end
	end

	assign out_data = out_data_q;

endmodule
`default_nettype wire

>>> rtl/linear_blend_skinning_vertex.sv
`timescale 1ns / 1ps
`default_nettype none
// Linear blend skinning of one vertex against a palette of 3x4 Q16.16 joint
// matrices. A palette word (tuser 0) is written when accepted. An influence
// (tuser 1) reads its joint's twelve entries through the single palette port
// and folds weight times entry into the accumulator with one shared
// multiplier, and no new item is taken until it is done; an influence on a
// joint outside the palette skips the reads. The influence marked tlast then
// runs the final transform (the same multiplier, two products per entry of the
// first three matrix columns) and loads the output word, and the accumulator
// comes out clear. A finished word waits in the output register while new
// items are taken.
module linear_blend_skinning_vertex (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// joint_index, element_index, palette_value, blend_weight, rest_px,
	// rest_py, rest_pz, rest_nx, rest_ny, rest_nz, then zero fill
	input  wire logic [lbs_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// req_type
	input  wire logic                          s_axis_tuser,
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// out_px, out_py, out_pz, out_nx, out_ny, out_nz
	output logic [lbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	lbs_pkg::cmd_t    cmd;
	lbs_pkg::status_t st;

	lbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	lbs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.st       (st),
		.out_data (m_axis_tdata)
	);

endmodule
`default_nettype wire

>>> tb/linear_blend_skinning_vertex_tb.sv
`timescale 1ns / 1ps
module linear_blend_skinning_vertex_tb;
	import lbs_pkg::*;

	// One word on the input stream, field by field.
	typedef struct packed {
		req_t               kind;
		logic [JOINT_W-1:0] joint;
		logic [ELEM_W-1:0]  elem;
		logic [VAL_W-1:0]   value;
		logic [WGT_W-1:0]   weight;
		logic [POS_W-1:0]   px;
		logic [POS_W-1:0]   py;
		logic [POS_W-1:0]   pz;
		logic [NRM_W-1:0]   nx;
		logic [NRM_W-1:0]   ny;
		logic [NRM_W-1:0]   nz;
		logic               last;
	} skin_req_t;

	// One skinned vertex on the output stream.
	typedef struct packed {
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		logic [NRM_W-1:0] nx;
		logic [NRM_W-1:0] ny;
		logic [NRM_W-1:0] nz;
	} skinned_t;

	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint POS_HI = 64'sd2147483647;
	localparam longint POS_LO = -POS_HI - 1;
	localparam longint NRM_HI = 64'sd32767;
	localparam longint NRM_LO = -NRM_HI - 1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	linear_blend_skinning_vertex dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Words waiting to be sent and skinned vertices waiting to arrive.
	skin_req_t pending_q[$];
	skin_req_t drv_req;
	skinned_t  skinned_q[$];
	skinned_t  want_out;

	// Predicted block state.
	logic signed [VAL_W-1:0] pal_word [PAL_DEPTH];
	longint                  blend_acc [MAT_ENTRIES] = '{default: 0};

	// Which palette entries the queued stimulus has written so far.
	logic [MAT_ENTRIES-1:0] elem_seen [JOINT_COUNT] = '{default: '0};
	logic [JOINT_W-1:0]     ready_joints[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int queued_count = 0;
	int errors = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Apply one accepted word to the predicted palette and accumulator.
	function automatic void skin_step(input skin_req_t it);
		longint w, s, sp, sn;
		longint mq [MAT_ENTRIES];
		longint p [3];
		longint n [3];
		longint pos_out [3];
		longint nrm_out [3];
		skinned_t res;
		int base, c, r;
		base = int'(it.joint) * MAT_ENTRIES;
		if (it.kind == REQ_WRITE) begin
			if (int'(it.elem) < MAT_ENTRIES && int'(it.joint) < JOINT_COUNT)
				pal_word[base + int'(it.elem)] = $signed(it.value);
		end else begin
			// Fold the clamped weight times each entry into the accumulator.
			if (int'(it.joint) < JOINT_COUNT) begin
				w = (it.weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(it.weight);
				for (c = 0; c < MAT_ENTRIES; c++) begin
					s = blend_acc[c] + w * longint'(pal_word[base + c]);
					blend_acc[c] = (s > ACC_HI) ? ACC_HI : ((s < ACC_LO) ? ACC_LO : s);
				end
			end
			// The last influence transforms the rest pose and clears the sum.
			if (it.last) begin
				for (c = 0; c < MAT_ENTRIES; c++)
					mq[c] = (blend_acc[c] + 64'sd32768) >>> 16;
				p[0] = longint'($signed(it.px));
				p[1] = longint'($signed(it.py));
				p[2] = longint'($signed(it.pz));
				n[0] = longint'($signed(it.nx));
				n[1] = longint'($signed(it.ny));
				n[2] = longint'($signed(it.nz));
				for (r = 0; r < 3; r++) begin
					sp = mq[r * 4 + 3];
					sn = 0;
					for (c = 0; c < 3; c++) begin
						sp += (mq[r * 4 + c] * p[c]) >>> 16;
						sn += mq[r * 4 + c] * n[c];
					end
					pos_out[r] = (sp > POS_HI) ? POS_HI : ((sp < POS_LO) ? POS_LO : sp);
					sn = (sn + 64'sd32768) >>> 16;
					nrm_out[r] = (sn > NRM_HI) ? NRM_HI : ((sn < NRM_LO) ? NRM_LO : sn);
				end
				res.px = pos_out[0][POS_W-1:0];
				res.py = pos_out[1][POS_W-1:0];
				res.pz = pos_out[2][POS_W-1:0];
				res.nx = nrm_out[0][NRM_W-1:0];
				res.ny = nrm_out[1][NRM_W-1:0];
				res.nz = nrm_out[2][NRM_W-1:0];
				skinned_q.push_back(res);
				for (c = 0; c < MAT_ENTRIES; c++)
					blend_acc[c] = 0;
			end
		end
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Matrix entry: mostly within +-2.0, or anything when wild.
	function automatic logic [VAL_W-1:0] matrix_word(input logic wild);
		int pick;
		logic [VAL_W-1:0] v;
		pick = $urandom_range(99);
		if (wild && pick < 15)
			return 32'h7fff_ffff;
		if (wild && pick < 30)
			return 32'h8000_0000;
		if (wild && pick < 60)
			return $urandom;
		v = $urandom_range(262143);
		return v - 32'd131072;
	endfunction

	// Rest coordinate: mostly moderate, sometimes at the extremes.
	function automatic logic [POS_W-1:0] coord_word();
		int pick;
		logic [POS_W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 10)
			return 32'h7fff_ffff;
		if (pick < 20)
			return 32'h8000_0000;
		if (pick < 40)
			return $urandom;
		v = $urandom_range(2097151);
		return v - 32'd1048576;
	endfunction

	// Blend weight, including zero, exactly one and values that clamp.
	function automatic logic [WGT_W-1:0] weight_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return WEIGHT_ONE;
		if (pick < 15)
			return '0;
		if (pick < 25)
			return WGT_W'($urandom_range(131071, 65537));
		return WGT_W'($urandom_range(65535));
	endfunction

	function automatic skin_req_t blank_req();
		skin_req_t it;
		it.kind = req_t'($urandom_range(1));
		it.joint = JOINT_W'($urandom_range(63));
		it.elem = ELEM_W'($urandom_range(15));
		it.value = $urandom;
		it.weight = WGT_W'($urandom_range(131071));
		it.px = coord_word();
		it.py = coord_word();
		it.pz = coord_word();
		it.nx = NRM_W'($urandom_range(65535));
		it.ny = NRM_W'($urandom_range(65535));
		it.nz = NRM_W'($urandom_range(65535));
		it.last = 1'($urandom_range(1));
		return it;
	endfunction

	// Queue a word and note which joints now have a complete matrix.
	function automatic void push_req(input skin_req_t it);
		if (it.kind == REQ_WRITE && int'(it.elem) < MAT_ENTRIES && !(&elem_seen[it.joint])) begin
			elem_seen[it.joint][it.elem] = 1'b1;
			if (&elem_seen[it.joint])
				ready_joints.push_back(it.joint);
		end
		pending_q.push_back(it);
		queued_count++;
	endfunction

	// Influences only ever use joints whose matrix is fully written.
	function automatic logic [JOINT_W-1:0] pick_joint();
		return ready_joints[$urandom_range(ready_joints.size() - 1)];
	endfunction

	// Mostly complete vertices, with matrix loads, stray words and broken vertices mixed in.
	task automatic queue_random(input int target);
		skin_req_t it;
		int start, pick, n_inf, e;
		logic [JOINT_W-1:0] j;
		logic wild;
		start = queued_count;
		while (queued_count - start < target) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				j = JOINT_W'($urandom_range(63));
				wild = ($urandom_range(99) < 20);
				for (e = 0; e < MAT_ENTRIES; e++) begin
					it = blank_req();
					it.kind = REQ_WRITE;
					it.joint = j;
					it.elem = e[ELEM_W-1:0];
					it.value = matrix_word(wild);
					push_req(it);
				end
			end else if (pick < 22) begin
				it = blank_req();
				if (it.kind == REQ_WRITE) begin
					it.value = matrix_word(1'b1);
				end else begin
					it.joint = pick_joint();
					it.weight = weight_word();
				end
				push_req(it);
			end else begin
				n_inf = $urandom_range(4, 1);
				for (e = 0; e < n_inf; e++) begin
					if ($urandom_range(99) < 8) begin
						it = blank_req();
						it.kind = REQ_WRITE;
						it.value = matrix_word(1'b0);
						push_req(it);
					end
					it = blank_req();
					it.kind = REQ_INFLUENCE;
					it.joint = pick_joint();
					it.weight = weight_word();
					it.last = (e == n_inf - 1);
					push_req(it);
				end
			end
		end
	endtask

	// Driver: present the next pending word once the current one is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				skin_step(drv_req);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_req = pending_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(IN_DATA_W - IN_BITS){1'b0}}, drv_req.nz, drv_req.ny,
						drv_req.nx, drv_req.pz, drv_req.py, drv_req.px, drv_req.weight,
						drv_req.value, drv_req.elem, drv_req.joint};
					s_axis_tuser <= drv_req.kind;
					s_axis_tlast <= drv_req.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each skinned word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (skinned_q.size() == 0) begin
					$display("%0t: skinned word with nothing expected, actual %h", $time,
						m_axis_tdata);
					errors++;
				end else begin
					want_out = skinned_q.pop_front();
					check_field("out_px", $signed(want_out.px),
						$signed(m_axis_tdata[0 +: POS_W]));
					check_field("out_py", $signed(want_out.py),
						$signed(m_axis_tdata[POS_W +: POS_W]));
					check_field("out_pz", $signed(want_out.pz),
						$signed(m_axis_tdata[2 * POS_W +: POS_W]));
					check_field("out_nx", $signed(want_out.nx),
						$signed(m_axis_tdata[3 * POS_W +: NRM_W]));
					check_field("out_ny", $signed(want_out.ny),
						$signed(m_axis_tdata[3 * POS_W + NRM_W +: NRM_W]));
					check_field("out_nz", $signed(want_out.nz),
						$signed(m_axis_tdata[3 * POS_W + 2 * NRM_W +: NRM_W]));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus and end of run.
	initial begin
		skin_req_t it;
		int e;
		send_idle_pct = 16;
		recv_idle_pct = 48;

		// Joint 0 gets the identity with a translation of (1.5, -2, 0).
		for (e = 0; e < MAT_ENTRIES; e++) begin
			it = blank_req();
			it.kind = REQ_WRITE;
			it.joint = '0;
			it.elem = e[ELEM_W-1:0];
			case (e)
				0, 5, 10: it.value = 32'h0001_0000;
				3:        it.value = 32'h0001_8000;
				7:        it.value = 32'hfffe_0000;
				default:  it.value = '0;
			endcase
			it.last = 1'b0;
			push_req(it);
		end

		// Writes past the last matrix entry are dropped, marked last or not.
		it = blank_req();
		it.kind = REQ_WRITE;
		it.joint = '0;
		it.elem = 4'd12;
		it.value = 32'hdead_beef;
		it.last = 1'b1;
		push_req(it);
		it.elem = 4'd15;
		it.value = 32'h8000_0000;
		it.last = 1'b0;
		push_req(it);

		// Full weight with rest coordinates at the extremes.
		it = blank_req();
		it.kind = REQ_INFLUENCE;
		it.joint = '0;
		it.weight = WEIGHT_ONE;
		it.px = 32'h7fff_ffff;
		it.py = 32'h8000_0000;
		it.pz = '0;
		it.nx = 16'h7fff;
		it.ny = 16'h8000;
		it.nz = '0;
		it.last = 1'b1;
		push_req(it);

		// A weight above one is clamped to one.
		it.weight = '1;
		it.px = 32'h0002_0000;
		it.py = 32'hffff_0000;
		it.pz = 32'h8000_0000;
		push_req(it);

		// Two halves make one.
		it.weight = WGT_W'(32768);
		it.last = 1'b0;
		push_req(it);
		it.last = 1'b1;
		push_req(it);

		// Zero weight leaves a zero transform.
		it.weight = '0;
		push_req(it);

		// A palette write marked last inside a vertex leaves the sum alone,
		// and two full weights are used unnormalized.
		it.weight = WEIGHT_ONE;
		it.last = 1'b0;
		push_req(it);
		it = blank_req();
		it.kind = REQ_WRITE;
		it.joint = 6'd63;
		it.elem = '0;
		it.value = 32'h7fff_ffff;
		it.last = 1'b1;
		push_req(it);
		it = blank_req();
		it.kind = REQ_INFLUENCE;
		it.joint = '0;
		it.weight = WEIGHT_ONE;
		it.last = 1'b1;
		push_req(it);

		queue_random(300);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0) @(posedge clk);
		send_idle_pct = 48;
		recv_idle_pct = 16;
		queue_random(320);

		while (pending_q.size() != 0) @(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(320);

		// Drain: last word accepted, every prediction met, then a quiet tail.
		while (pending_q.size() != 0) @(posedge clk);
		@(posedge clk);
		while (s_axis_tvalid) @(posedge clk);
		while (skinned_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lbs_pkg.sv
rtl/lbs_ctrl.sv
rtl/lbs_dp.sv
rtl/linear_blend_skinning_vertex.sv
tb/linear_blend_skinning_vertex_tb.sv
